// ===== rtl/rgb_brightness_contrast_saturation_top_macros.svh =====
// assertion macros used by the rtl of the color adjust block
`ifndef RGB_BRIGHTNESS_CONTRAST_SATURATION_TOP_MACROS_SVH
`define RGB_BRIGHTNESS_CONTRAST_SATURATION_TOP_MACROS_SVH

// same-cycle implication, sampled on clk and quiet during rst
`define BCS_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bcs same-cycle check failed");

// next-cycle implication, sampled on clk and quiet during rst
`define BCS_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("bcs next-cycle check failed");

`endif

// ===== rtl/bcs_pkg.sv =====
// shared types, constants and helpers of the color adjust block
`timescale 1ns / 1ps
`default_nettype none

package bcs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd2;

  localparam logic signed [7:0] LEVEL_MIN = -8'sd100;
  localparam logic signed [7:0] LEVEL_MAX = 8'sd100;
  localparam logic [7:0]        UNITY_GAIN = 8'd100;

  // x/100 = (x * 5243) >> 19, exact for 0 <= x < 25600
  localparam logic [12:0] RECIP_100       = 13'd5243;
  localparam int          RECIP_100_SHIFT = 19;
  // x/3 = (x * 683) >> 11, exact for 0 <= x <= 765
  localparam logic [9:0]  RECIP_3         = 10'd683;
  localparam int          RECIP_3_SHIFT   = 11;

  // any total at or above this gives 255 after the divide
  localparam int SAT_NUM = 25600;

  typedef struct packed {
    logic signed [8:0] offset;         // brightness offset, -255..255
    logic [7:0]        contrast_gain;  // 100 + level, 0..200
    logic [7:0]        sat_gain;       // 100 + level, 0..200
  } cfg_t;

  // floor(num/100) clamped to a byte, num given as its reciprocal product
  function automatic logic [7:0] div100_clamp(input logic [27:0] prod,
                                              input logic        neg,
                                              input logic        sat);
    logic [7:0] res;
    res = prod[RECIP_100_SHIFT +: 8];
    if (neg) begin
      res = 8'd0;
    end else if (sat) begin
      res = 8'd255;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bcs_cfg.sv =====
// configuration registers with level clamping and derived gains
`timescale 1ns / 1ps
`default_nettype none

module bcs_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [bcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bcs_pkg::cfg_t                        cfg
);

  logic signed [7:0]  raw;
  logic signed [7:0]  level;
  logic [6:0]         mag;
  logic [14:0]        mag255;
  logic [27:0]        off_prod;
  logic [7:0]         off_mag;
  logic signed [8:0]  offset_next;
  logic signed [8:0]  gain_wide;
  logic [7:0]         gain_next;
  bcs_pkg::cfg_t      cfg_q;

  always_comb begin
    raw = $signed(cfg_data);
    priority if (raw < bcs_pkg::LEVEL_MIN) begin
      level = bcs_pkg::LEVEL_MIN;
    end else if (raw > bcs_pkg::LEVEL_MAX) begin
      level = bcs_pkg::LEVEL_MAX;
    end else begin
      level = raw;
    end
    mag      = level[7] ? 7'(-level) : level[6:0];
    // mag * 255 as a shift and subtract
    mag255   = {mag, 8'b0} - 15'(mag);
    off_prod = 28'(mag255) * 28'(bcs_pkg::RECIP_100);
    off_mag  = off_prod[bcs_pkg::RECIP_100_SHIFT +: 8];
    offset_next = level[7] ? -$signed({1'b0, off_mag}) : $signed({1'b0, off_mag});
    gain_wide   = 9'($signed(level)) + $signed({1'b0, bcs_pkg::UNITY_GAIN});
    gain_next   = gain_wide[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.offset        <= '0;
      cfg_q.contrast_gain <= bcs_pkg::UNITY_GAIN;
      cfg_q.sat_gain      <= bcs_pkg::UNITY_GAIN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bcs_pkg::REG_BRIGHTNESS: cfg_q.offset        <= offset_next;
        bcs_pkg::REG_CONTRAST:   cfg_q.contrast_gain <= gain_next;
        bcs_pkg::REG_SATURATION: cfg_q.sat_gain      <= gain_next;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/rgb_brightness_contrast_saturation_top.sv =====
// brightness, contrast and saturation adjust of an rgba pixel stream
// Usage:
//   input channel: in_valid / in_stall with in_red, in_green, in_blue, in_alpha.
//   A pixel transfers on a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with out_red .. out_alpha, same rule.
//   Registers are written through cfg_write / cfg_index / cfg_data
//   (0 brightness, 1 contrast, 2 saturation, signed percent, clamped to
//   -100..100); write them only while no pixel is in flight.
//   Throughput is one pixel per clock while out_stall stays low: eight
//   register stages (brightness, contrast multiply, contrast divide, gray
//   sum, gray divide, saturation multiply, saturation divide, clamp) each
//   hold their own valid bit.
//   A stalled receiver freezes only the stages that are full; empty stages
//   behind it keep filling, so in_stall rises only when all eight hold pixels.
//   Reset clears all valid bits and sets every register to zero (no change).
//   Alpha rides along untouched.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_brightness_contrast_saturation_top_macros.svh"

module rgb_brightness_contrast_saturation_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [bcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_red,
  input  wire logic [7:0]                      in_green,
  input  wire logic [7:0]                      in_blue,
  input  wire logic [7:0]                      in_alpha,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue,
  output logic [7:0]                           out_alpha
);

  bcs_pkg::cfg_t cfg;

  bcs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline control
  logic [8:1] vld;
  logic [8:1] vprev;
  logic [8:1] rdy;
  logic [8:1] ld;

  assign vprev = {vld[7:1], in_valid};

  always_comb begin
    rdy[8] = !vld[8] || !out_stall;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign ld = rdy & vprev;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= 8; k++) begin
        if (rdy[k]) begin
          vld[k] <= vprev[k];
        end
      end
    end
  end

  // stage data
  logic [7:0]         in_ch   [3];
  logic [7:0]         alpha_q [1:8];
  logic signed [9:0]  bsum    [3];
  logic [7:0]         ch1     [3];
  logic signed [9:0]  cdiff   [3];
  logic signed [19:0] cprod   [3];
  logic signed [19:0] cnum_c  [3];
  logic signed [16:0] cnum2   [3];
  logic [27:0]        cmul3   [3];
  logic               cneg3   [3];
  logic               csat3   [3];
  logic [7:0]         ch4_c   [3];
  logic [7:0]         ch4     [3];
  logic [9:0]         sum4;
  logic [9:0]         sum4_q;
  logic [7:0]         ch5     [3];
  logic [18:0]        gmul5;
  logic [7:0]         gray;
  logic signed [9:0]  sdiff   [3];
  logic signed [19:0] snum_c  [3];
  logic signed [17:0] snum6   [3];
  logic [27:0]        smul7   [3];
  logic               sneg7   [3];
  logic               ssat7   [3];
  logic [7:0]         ch8     [3];

  assign in_ch[0] = in_red;
  assign in_ch[1] = in_green;
  assign in_ch[2] = in_blue;

  always_comb begin
    gray = gmul5[bcs_pkg::RECIP_3_SHIFT +: 8];
    for (int i = 0; i < 3; i++) begin
      bsum[i]   = $signed({2'b00, in_ch[i]}) + 10'(cfg.offset);
      cdiff[i]  = $signed({2'b00, ch1[i]}) - 10'sd128;
      cprod[i]  = cdiff[i] * $signed({2'b00, cfg.contrast_gain});
      cnum_c[i] = cprod[i] + 20'sd12800;
      ch4_c[i]  = bcs_pkg::div100_clamp(cmul3[i], cneg3[i], csat3[i]);
      sdiff[i]  = $signed({2'b00, ch5[i]}) - $signed({2'b00, gray});
      snum_c[i] = sdiff[i] * $signed({2'b00, cfg.sat_gain})
                + $signed(20'(gray) * 20'd100);
    end
    sum4 = 10'(ch4_c[0]) + 10'(ch4_c[1]) + 10'(ch4_c[2]);
  end

  // alpha shift line
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      alpha_q[1] <= in_alpha;
    end
    for (int k = 2; k <= 8; k++) begin
      if (ld[k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  // brightness: add offset and clamp
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) begin
        priority if (bsum[i] < 10'sd0) begin
          ch1[i] <= 8'd0;
        end else if (bsum[i] > 10'sd255) begin
          ch1[i] <= 8'd255;
        end else begin
          ch1[i] <= bsum[i][7:0];
        end
      end
    end
  end

  // contrast total about mid gray
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        cnum2[i] <= cnum_c[i][16:0];
      end
    end
  end

  // contrast divide by 100
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int i = 0; i < 3; i++) begin
        cmul3[i] <= 28'(cnum2[i][14:0]) * 28'(bcs_pkg::RECIP_100);
        cneg3[i] <= cnum2[i][16];
        csat3[i] <= cnum2[i] >= 17'(bcs_pkg::SAT_NUM);
      end
    end
  end

  // contrast clamp and channel sum
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      ch4  <= ch4_c;
      sum4_q <= sum4;
    end
  end

  // gray = sum / 3
  always_ff @(posedge clk) begin
    if (ld[5]) begin
      ch5   <= ch4;
      gmul5 <= 19'(sum4_q) * 19'(bcs_pkg::RECIP_3);
    end
  end

  // saturation total about gray
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      for (int i = 0; i < 3; i++) begin
        snum6[i] <= snum_c[i][17:0];
      end
    end
  end

  // saturation divide by 100
  always_ff @(posedge clk) begin
    if (ld[7]) begin
      for (int i = 0; i < 3; i++) begin
        smul7[i] <= 28'(snum6[i][14:0]) * 28'(bcs_pkg::RECIP_100);
        sneg7[i] <= snum6[i][17];
        ssat7[i] <= snum6[i] >= 18'(bcs_pkg::SAT_NUM);
      end
    end
  end

  // final clamp into the output register
  always_ff @(posedge clk) begin
    if (ld[8]) begin
      for (int i = 0; i < 3; i++) begin
        ch8[i] <= bcs_pkg::div100_clamp(smul7[i], sneg7[i], ssat7[i]);
      end
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld[8];
  assign out_red   = ch8[0];
  assign out_green = ch8[1];
  assign out_blue  = ch8[2];
  assign out_alpha = alpha_q[8];

  // an input transfer always lands in the first stage
  `BCS_ASSERT_NXT(a_in_lands, in_valid && !in_stall, vld[1])
  // the fourth stage only holds back when it and the fifth stage are both full
  `BCS_ASSERT_IMP(a_stall_full, !rdy[4], vld[4] && vld[5] && !rdy[5])
  // a blocked mid stage keeps its pixel
  `BCS_ASSERT_NXT(a_mid_hold, vld[4] && !rdy[4], vld[4] && $stable(sum4_q))

endmodule

`default_nettype wire

// ===== verif/rgb_brightness_contrast_saturation_top_test.sv =====
// self-checking testbench of the rgb brightness, contrast and saturation adjuster
`timescale 1ns / 1ps

module rgb_brightness_contrast_saturation_top_test;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  localparam logic [bcs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PIPE_DEPTH    = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_PIXELS  = 125;

  class adjust_scoreboard;
    int    bright_pct;
    int    contrast_pct;
    int    sat_pct;
    rgba_t expected_pixels[$];
    int    errors;
    int    checked;

    function new();
      bright_pct   = 0;
      contrast_pct = 0;
      sat_pct      = 0;
      errors       = 0;
      checked      = 0;
    endfunction

    // raw register byte as a signed percent limited to -100..100
    function int level_of(logic [7:0] raw);
      int v;
      v = int'($signed(raw));
      if (v < -100) v = -100;
      if (v > 100) v = 100;
      return v;
    endfunction

    function void set_reg(logic [bcs_pkg::CFG_IDX_W-1:0] idx, logic [7:0] raw);
      case (idx)
        bcs_pkg::REG_BRIGHTNESS: bright_pct = level_of(raw);
        bcs_pkg::REG_CONTRAST:   contrast_pct = level_of(raw);
        bcs_pkg::REG_SATURATION: sat_pct = level_of(raw);
        default: ;
      endcase
    endfunction

    function int byte_clamp(int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    // floor of num/100, negative totals give black
    function int percent_clamp(int num);
      if (num < 0) return 0;
      return byte_clamp(num / 100);
    endfunction

    function rgba_t adjust_pixel(rgba_t px);
      int    ch[3];
      int    mag;
      int    off;
      int    gain;
      int    gray;
      rgba_t res;
      ch[0] = px.red;
      ch[1] = px.green;
      ch[2] = px.blue;
      if (bright_pct != 0) begin
        mag = (bright_pct < 0) ? -bright_pct : bright_pct;
        off = (mag * 255) / 100;
        if (bright_pct < 0) off = -off;
        foreach (ch[i]) ch[i] = byte_clamp(ch[i] + off);
      end
      if (contrast_pct != 0) begin
        gain = 100 + contrast_pct;
        foreach (ch[i]) ch[i] = percent_clamp((ch[i] - 128) * gain + 12800);
      end
      if (sat_pct != 0) begin
        gain = 100 + sat_pct;
        gray = (ch[0] + ch[1] + ch[2]) / 3;
        foreach (ch[i]) ch[i] = percent_clamp(gray * 100 + (ch[i] - gray) * gain);
      end
      res.red   = ch[0][7:0];
      res.green = ch[1][7:0];
      res.blue  = ch[2][7:0];
      res.alpha = px.alpha;
      return res;
    endfunction

    function void note_pixel(rgba_t px);
      expected_pixels.push_back(adjust_pixel(px));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(rgba_t got);
      rgba_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none got %h", $time, got);
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_red = '0;
  logic [7:0]                     in_green = '0;
  logic [7:0]                     in_blue = '0;
  logic [7:0]                     in_alpha = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     out_red;
  logic [7:0]                     out_green;
  logic [7:0]                     out_blue;
  logic [7:0]                     out_alpha;

  adjust_scoreboard sb;
  bit no_idle   = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_off  = 1'b0;
  int pixels_sent = 0;
  int settings_run = 1;

  rgb_brightness_contrast_saturation_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("rgb_brightness_contrast_saturation_top test failed");
    $finish;
  end

  task automatic write_reg(input logic [bcs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] raw);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= raw;
    @(posedge clk);
    sb.set_reg(idx, raw);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_levels(input logic [7:0] b, input logic [7:0] c, input logic [7:0] s);
    write_reg(bcs_pkg::REG_BRIGHTNESS, b);
    write_reg(bcs_pkg::REG_CONTRAST, c);
    write_reg(bcs_pkg::REG_SATURATION, s);
    settings_run++;
  endtask

  task automatic send_pixel(input rgba_t px);
    int gap;
    gap = (no_idle || hold_req || hold_off) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    in_alpha <= px.alpha;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  // stop offering and let the pipeline empty before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  function automatic rgba_t random_pixel();
    rgba_t px;
    px = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        px.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
        px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
        px.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      1: begin
        px.green = px.red ^ 8'($urandom_range(0, 7));
        px.blue  = px.red ^ 8'($urandom_range(0, 7));
      end
      2: begin
        px.red   = 8'($urandom_range(112, 144));
        px.green = 8'($urandom_range(112, 144));
        px.blue  = 8'($urandom_range(112, 144));
      end
      default: ;
    endcase
    return px;
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 9))
      0, 1: return 8'd0;
      2: return 8'd100;
      3: return 8'(-100);
      4: return $urandom_range(0, 1) ? 8'($urandom_range(101, 127))
                                     : 8'($urandom_range(128, 155));
      default: return 8'($urandom_range(0, 200) - 100);
    endcase
  endfunction

  // output side: random stall after each transfer, one long hold-off on request
  initial begin
    int wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (hold_req) begin
          hold_req = 1'b0;
          hold_off = 1'b1;
          wait_cycles = HOLD_CYCLES;
        end else begin
          wait_cycles = no_idle ? 0 : $urandom_range(0, 19);
        end
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
          out_stall <= 1'b0;
        end
        hold_off = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_pixel({out_red, out_green, out_blue, out_alpha});
    end
  end

  initial begin
    logic [7:0] b_lvl;
    logic [7:0] c_lvl;
    logic [7:0] s_lvl;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at their reset value: straight pass-through
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel({8'd1, 8'd2, 8'd3, 8'd128});

    // brightness full up, plus a write to the unused index that must not land
    drain();
    set_levels(8'd100, 8'd0, 8'd0);
    write_reg(REG_UNUSED, 8'h55);
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel({8'd200, 8'd10, 8'd255, 8'd7});

    // brightness below range, stored as full down
    drain();
    set_levels(8'h80, 8'd0, 8'd0);
    send_pixel({8'd255, 8'd128, 8'd0, 8'd255});
    send_pixel({8'd254, 8'd255, 8'd1, 8'd1});

    // contrast doubled, dark channels go negative before the clamp
    drain();
    set_levels(8'd0, 8'd100, 8'd0);
    send_pixel({8'd0, 8'd128, 8'd255, 8'd9});
    send_pixel({8'd60, 8'd200, 8'd127, 8'd90});

    // contrast gain of zero, flattens everything to mid gray
    drain();
    set_levels(8'd0, 8'h81, 8'd0);
    send_pixel({8'd0, 8'd77, 8'd255, 8'd200});

    // saturation above range, stored as doubled
    drain();
    set_levels(8'd0, 8'd0, 8'd127);
    send_pixel({8'd255, 8'd0, 8'd0, 8'd33});
    send_pixel({8'd10, 8'd240, 8'd30, 8'd66});

    // saturation fully off: gray
    drain();
    set_levels(8'd0, 8'd0, 8'(-100));
    send_pixel({8'd255, 8'd0, 8'd128, 8'd99});

    // all three stages together
    drain();
    set_levels(8'd37, 8'(-45), 8'd80);
    send_pixel({8'd12, 8'd250, 8'd131, 8'd170});
    send_pixel({8'd255, 8'd255, 8'd0, 8'd0});
    send_pixel({8'd90, 8'd91, 8'd92, 8'd255});

    drain();
    set_levels(8'hff, 8'd1, 8'hff);
    send_pixel({8'd1, 8'd128, 8'd254, 8'd2});
    send_pixel({8'd127, 8'd129, 8'd64, 8'd3});

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin b_lvl = 8'd100; c_lvl = 8'd100; s_lvl = 8'd100; end
        1: begin b_lvl = 8'(-100); c_lvl = 8'(-100); s_lvl = 8'(-100); end
        2: begin b_lvl = 8'h7f; c_lvl = 8'h80; s_lvl = 8'd0; end
        default: begin
          b_lvl = random_level();
          c_lvl = random_level();
          s_lvl = random_level();
        end
      endcase
      set_levels(b_lvl, c_lvl, s_lvl);
      if (ph % 3 == 0) write_reg(REG_UNUSED, 8'($urandom));
      no_idle = (ph % 4 == 3);
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        // ask the output side to hold off while pixels keep coming in
        if (ph == 5 && k == 20) hold_req = 1'b1;
        send_pixel(random_pixel());
      end
    end

    drain();
    $display("%0d pixels sent, %0d checked, over %0d register settings",
             pixels_sent, sb.checked, settings_run);
    $display("covered every stage alone and combined, clamped levels and a full pipeline");
    if (sb.errors == 0) begin
      $display("rgb_brightness_contrast_saturation_top test passed");
    end else begin
      $display("rgb_brightness_contrast_saturation_top test failed");
    end
    $finish;
  end

endmodule
